@@ hw/rtl/rrsg_pkg.sv @@
package rrsg_pkg;

    localparam int DIM_W   = 15;
    localparam int RAD_W   = 5;
    localparam int CIRC_W  = 6;
    localparam int ERR_W   = 8;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MID,
        FR_STEP
    } front_state_t;

    // One request for the back end: the middle band or one circle step.
    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [RAD_W-1:0] r;
        logic             mid;
        logic [RAD_W-1:0] xi;
        logic [RAD_W-1:0] yi;
        logic             four;
        logic             is_last;
    } rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // True when the circle loop produces another emitting step from this state.
    function automatic logic has_next(input logic [CIRC_W-1:0] xi,
                                      input logic [CIRC_W-1:0] yi,
                                      input logic signed [ERR_W-1:0] p);
        logic [CIRC_W-1:0] xn;
        logic [CIRC_W-1:0] yn;
        yn = yi + CIRC_W'(1);
        xn = (p > 0) ? (xi - CIRC_W'(1)) : xi;
        return (xi > yi) && !(xn < yn);
    endfunction

endpackage

@@ hw/rtl/rrsg_front.sv @@
module rrsg_front #(
    parameter int MAX_RADIUS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rrsg_pkg::DIM_W-1:0]  in_w,
    input  logic [rrsg_pkg::DIM_W-1:0]  in_h,
    input  logic [7:0]                  in_r,
    output logic                        push_valid,
    input  logic                        push_ready,
    output rrsg_pkg::rec_t              push_rec
);

    localparam int DW = rrsg_pkg::DIM_W;
    localparam int RW = rrsg_pkg::RAD_W;
    localparam int CW = rrsg_pkg::CIRC_W;
    localparam int EW = rrsg_pkg::ERR_W;

    rrsg_pkg::front_state_t state_reg, state_next;

    logic [DW-1:0]        w_reg, h_reg;
    logic [RW-1:0]        r_reg;
    logic [CW-1:0]        xi_reg, xi_next;
    logic [CW-1:0]        yi_reg, yi_next;
    logic signed [EW-1:0] p_reg, p_next;

    logic [DW-1:0]        r_clamp;
    logic [CW-1:0]        xi1, yi1;
    logic signed [EW-1:0] p_dec, p1, p_init;
    logic                 dec;
    logic                 more_mid, more_step;

    // Clamp the radius to half width, half height and the limit.
    always_comb
    begin
        r_clamp = {7'd0, in_r};
        if (r_clamp > (in_w >> 1))
            r_clamp = in_w >> 1;
        if (r_clamp > (in_h >> 1))
            r_clamp = in_h >> 1;
        if (r_clamp > DW'(MAX_RADIUS))
            r_clamp = DW'(MAX_RADIUS);
    end

    // One midpoint step from the held state.
    always_comb
    begin
        dec   = (p_reg > 0);
        yi1   = yi_reg + CW'(1);
        xi1   = dec ? (xi_reg - CW'(1)) : xi_reg;
        p_dec = dec ? (p_reg - $signed({{(EW-CW-1){1'b0}}, xi1, 1'b0})) : p_reg;
        p1    = p_dec + $signed({{(EW-CW-1){1'b0}}, yi1, 1'b0}) + EW'(1);
        p_init = EW'(1) - $signed({{(EW-RW){1'b0}}, r_reg});
        more_mid  = rrsg_pkg::has_next(CW'(r_reg), CW'(0), p_init);
        more_step = rrsg_pkg::has_next(xi1, yi1, p1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rrsg_pkg::FR_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            w_reg <= in_w;
            h_reg <= in_h;
            r_reg <= r_clamp[RW-1:0];
        end
        xi_reg <= xi_next;
        yi_reg <= yi_next;
        p_reg  <= p_next;
    end

    always_comb
    begin
        state_next = state_reg;
        xi_next    = xi_reg;
        yi_next    = yi_reg;
        p_next     = p_reg;
        in_ready   = 1'b0;
        push_valid = 1'b0;
        push_rec.w    = w_reg;
        push_rec.h    = h_reg;
        push_rec.r    = r_reg;
        push_rec.mid  = 1'b0;
        push_rec.xi   = xi1[RW-1:0];
        push_rec.yi   = yi1[RW-1:0];
        push_rec.four = (xi1 != yi1);
        push_rec.is_last = !more_step;
        unique case (state_reg)
            rrsg_pkg::FR_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = rrsg_pkg::FR_MID;
            end
            rrsg_pkg::FR_MID:
            begin
                push_valid       = 1'b1;
                push_rec.mid     = 1'b1;
                push_rec.is_last = !more_mid;
                if (push_ready)
                begin
                    xi_next    = CW'(r_reg);
                    yi_next    = CW'(0);
                    p_next     = p_init;
                    state_next = more_mid ? rrsg_pkg::FR_STEP : rrsg_pkg::FR_IDLE;
                end
            end
            rrsg_pkg::FR_STEP:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    xi_next = xi1;
                    yi_next = yi1;
                    p_next  = p1;
                    if (!more_step)
                        state_next = rrsg_pkg::FR_IDLE;
                end
            end
            default:
            begin
                state_next = rrsg_pkg::FR_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/rrsg_fifo.sv @@
module rrsg_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  rrsg_pkg::rec_t    push_rec,
    input  logic              pop,
    output rrsg_pkg::rec_t    head_rec,
    output rrsg_pkg::q_stat_t stat
);

    rrsg_pkg::rec_t mem_reg [rrsg_pkg::Q_DEPTH];

    logic [rrsg_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rrsg_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rrsg_pkg::Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic                         do_push, do_pop;

    always_comb
    begin
        stat.full   = (cnt_reg == rrsg_pkg::Q_CNT_W'(rrsg_pkg::Q_DEPTH));
        stat.empty  = (cnt_reg == '0);
        push_ready  = !stat.full;
        do_push     = push_valid && !stat.full;
        do_pop      = pop && !stat.empty;
        wr_ptr_next = do_push ? (wr_ptr_reg + rrsg_pkg::Q_PTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = do_pop ? (rd_ptr_reg + rrsg_pkg::Q_PTR_W'(1)) : rd_ptr_reg;
        cnt_next    = cnt_reg + rrsg_pkg::Q_CNT_W'(do_push) - rrsg_pkg::Q_CNT_W'(do_pop);
        head_rec    = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

@@ hw/rtl/rrsg_back.sv @@
module rrsg_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rrsg_pkg::rec_t             head_rec,
    input  logic                       head_valid,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rrsg_pkg::DIM_W-1:0] out_x,
    output logic [rrsg_pkg::DIM_W-1:0] out_y,
    output logic [rrsg_pkg::DIM_W-1:0] out_w,
    output logic [rrsg_pkg::DIM_W-1:0] out_h,
    output logic                       out_last
);

    localparam int DW = rrsg_pkg::DIM_W;
    localparam int RW = rrsg_pkg::RAD_W;

    logic [1:0]    idx_reg, idx_next;
    logic          valid_reg, valid_next;
    logic [DW-1:0] x_reg, y_reg, w_reg, h_reg;
    logic          last_reg;

    logic [DW-1:0] x_next, y_next, w_next, h_next;
    logic [DW-1:0] r15, a15, b15, band_w;
    logic [1:0]    last_idx;
    logic          load, end_rec;

    always_comb
    begin
        r15    = {{(DW-RW){1'b0}}, head_rec.r};
        a15    = {{(DW-RW){1'b0}}, idx_reg[1] ? head_rec.yi : head_rec.xi};
        b15    = {{(DW-RW){1'b0}}, idx_reg[1] ? head_rec.xi : head_rec.yi};
        band_w = head_rec.w - (r15 << 1);
        if (head_rec.mid)
            last_idx = 2'd0;
        else if (head_rec.four)
            last_idx = 2'd3;
        else
            last_idx = 2'd1;
        end_rec = (idx_reg == last_idx);
        load    = head_valid && (!valid_reg || out_ready);
        pop     = load && end_rec;

        // Even sub-index takes the upper half of the corner, odd the lower half.
        if (head_rec.mid)
        begin
            x_next = '0;
            y_next = r15;
            w_next = head_rec.w;
            h_next = head_rec.h - (r15 << 1);
        end
        else
        begin
            x_next = r15 - a15;
            w_next = band_w + (a15 << 1);
            h_next = DW'(1);
            if (idx_reg[0])
                y_next = head_rec.h - r15 - DW'(1) + b15;
            else
                y_next = r15 - b15;
        end

        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = end_rec ? 2'd0 : (idx_reg + 2'd1);
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            w_reg    <= w_next;
            h_reg    <= h_next;
            last_reg <= head_rec.is_last && end_rec;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_w     = w_reg;
    assign out_h     = h_reg;
    assign out_last  = last_reg;

endmodule

@@ hw/rtl/rounded_rect_span_generator.sv @@
// A taken request is registered in the front, queued, then loaded into the back end's
// single output register. Throughput: one span per cycle while m_axis_tready is high
// and the queue is not empty; the front stepper runs one circle step per cycle while the
// queue has room and takes a new request only after the last step of the one before.
// Reset: rst_n clears the front state machine, queue pointers and output valid;
// payload registers keep whatever they hold.
module rounded_rect_span_generator #(
    parameter int MAX_RADIUS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // rect_w[14:0], rect_h[29:15], corner_radius[37:30]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // span_x[14:0], span_y[29:15], span_w[44:30],
                                        // span_h[59:45]
    output logic        m_axis_tlast    // last
);

    localparam int DW = rrsg_pkg::DIM_W;

    rrsg_pkg::rec_t    push_rec, head_rec;
    rrsg_pkg::q_stat_t q_stat;
    logic              push_valid, push_ready, pop;
    logic [DW-1:0]     span_x, span_y, span_w, span_h;

    // Front: clamp radius, walk midpoint circle one step a cycle while queue has room.
    rrsg_front #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_w       (s_axis_tdata[14:0]),
        .in_h       (s_axis_tdata[29:15]),
        .in_r       (s_axis_tdata[37:30]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec)
    );

    // Short queue of step requests decouples the stepper from output stalls.
    rrsg_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .pop        (pop),
        .head_rec   (head_rec),
        .stat       (q_stat)
    );

    // Back: one, two or four spans per request, one per cycle while tready is high.
    rrsg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_rec   (head_rec),
        .head_valid (!q_stat.empty),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_x      (span_x),
        .out_y      (span_y),
        .out_w      (span_w),
        .out_h      (span_h),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, span_h, span_w, span_y, span_x};

    // Queue cannot report full and empty together.
    a_q_stat: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    // Front drops ready for at least the cycle after taking a request.
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("front took back-to-back requests");

    // Back pops only a present entry.
    a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // Output valid rises only after a queue entry was present.
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!q_stat.empty))
        else $error("output valid without a queued step");

endmodule
